FILE: rtl/core/bcdec_pkg.sv
// Shared types and constants for the BC1/BC2/BC3 block decoder.
package bcdec_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] REG_FORMAT_MODE = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SWAP_HALFWORDS = 1'b1;

  // format_mode codes
  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  // where a texel's alpha comes from
  typedef enum logic [1:0] {
    ASRC_COLOR    = 2'd0,
    ASRC_EXPLICIT = 2'd1,
    ASRC_INTERP   = 2'd2
  } asrc_e;

  // endpoint stage: expanded endpoints and undivided interpolation sums
  typedef struct packed {
    logic [2:0][7:0]  e0;         // index 0 red, 1 green, 2 blue
    logic [2:0][7:0]  e1;
    logic [2:0][9:0]  sum_m;      // 2*e0+e1, or e0+e1 in 3-colour mode
    logic [2:0][9:0]  sum_n;      // e0+2*e1, or zero in 3-colour mode
    logic             four_col;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [5:0][10:0] a_sum;      // weighted alpha sums for palette entries 2..7
    logic             a_six;
    logic [3:0][7:0]  col_rows;   // 2-bit colour indexes, one byte per row
    logic [63:0]      alpha_raw;
    asrc_e            asrc;
  } ep_t;

  // palette stage: everything the row emitter needs
  typedef struct packed {
    logic [3:0][23:0] cpal;       // {blue, green, red}
    logic             transp3;    // colour index 3 is transparent black
    logic [7:0][7:0]  apal;
    logic [3:0][7:0]  col_rows;
    logic [63:0]      alpha_raw;
    asrc_e            asrc;
  } pal_t;

endpackage

FILE: rtl/core/bc1_bc2_bc3_block_decoder_top.sv
// BC1/BC2/BC3 texture block decoder top level.
//
// Input channel (in_valid_i/in_ready_o) takes one 16-byte compressed block as
// block_low_i (bytes 0..7) and block_high_i (bytes 8..15). Output channel
// (out_valid_o/out_ready_i) returns four items per block, rows 0..3 of texels,
// with last_row_o set on row 3. Each texel is RGBA8, red in the low byte.
// cfg_we_i writes format_mode (index 0) or swap_halfwords (index 1);
// change them only while the block is idle.
// Pipeline: input register, endpoint register, palette register, output
// register. Row 0 of a block reaches the output register after the input,
// endpoint and palette registers; rows follow on consecutive cycles when the
// receiver is ready. The palette register emits one row per cycle while the
// output is free and takes the next block after its last row; up to four
// blocks are in flight, the oldest as its last row in the output register.
// Reset clears all valid flags and the row counter and loads format_mode = 0
// (BC1) and swap_halfwords = 1. When out_ready_i is low the output item holds
// and the stages behind fill up, then in_ready_o drops.
module bc1_bc2_bc3_block_decoder_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bcdec_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bcdec_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [63:0]                        block_low_i,
  input  logic [63:0]                        block_high_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        texel_col0_o,
  output logic [31:0]                        texel_col1_o,
  output logic [31:0]                        texel_col2_o,
  output logic [31:0]                        texel_col3_o,
  output logic [1:0]                         row_index_o,
  output logic                               last_row_o
);
  import bcdec_pkg::*;

  function automatic logic [63:0] swap16(input logic [63:0] x);
    logic [3:0][15:0] w;
    logic [3:0][15:0] r;
    begin
      w = x;
      for (int i = 0; i < 4; i++) begin
        r[i] = {w[i][7:0], w[i][15:8]};
      end
      swap16 = r;
    end
  endfunction

  // configuration
  logic [1:0] fmt_q;
  logic       swap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= FMT_BC1;
      swap_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FORMAT_MODE:    fmt_q  <= cfg_wdata_i[1:0];
        REG_SWAP_HALFWORDS: swap_q <= cfg_wdata_i[0];
        default:            ;
      endcase
    end
  end

  asrc_e asrc_cfg;
  always_comb begin
    unique case (fmt_q)
      FMT_BC1: asrc_cfg = ASRC_COLOR;
      FMT_BC2: asrc_cfg = ASRC_EXPLICIT;
      FMT_BC3: asrc_cfg = ASRC_INTERP;
      default: asrc_cfg = ASRC_INTERP;  // bit 1 selects interpolated alpha
    endcase
  end

  // stage control
  logic       s0_valid_q, s1_valid_q, s2_valid_q, out_valid_q;
  logic [1:0] row_q;
  logic       out_free, s2_done, s2_free, s1_free, s0_free, s2_emit;

  assign out_free = !out_valid_q || out_ready_i;
  assign s2_emit  = s2_valid_q && out_free;
  assign s2_done  = s2_emit && (row_q == 2'd3);
  assign s2_free  = !s2_valid_q || s2_done;
  assign s1_free  = !s1_valid_q || s2_free;
  assign s0_free  = !s0_valid_q || s1_free;
  assign in_ready_o = s0_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      row_q       <= 2'd0;
    end else begin
      if (s0_free) s0_valid_q <= in_valid_i;
      if (s1_free) s1_valid_q <= s0_valid_q;
      if (s2_free) s2_valid_q <= s1_valid_q;
      if (out_free) out_valid_q <= s2_valid_q;
      if (s2_emit) row_q <= 2'(row_q + 2'd1);
    end
  end

  // input register
  logic [63:0] lo_q, hi_q;
  asrc_e       asrc_q;

  always_ff @(posedge clk_i) begin
    if (s0_free && in_valid_i) begin
      lo_q   <= swap_q ? swap16(block_low_i) : block_low_i;
      hi_q   <= swap_q ? swap16(block_high_i) : block_high_i;
      asrc_q <= asrc_cfg;
    end
  end

  // endpoint register
  ep_t ep_d, ep_q;

  bcdec_endpoints u_endpoints (
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .asrc_i (asrc_q),
    .ep_o   (ep_d)
  );

  always_ff @(posedge clk_i) begin
    if (s1_free && s0_valid_q) ep_q <= ep_d;
  end

  // palette register
  pal_t pal_d, pal_q;

  bcdec_palette u_palette (
    .ep_i  (ep_q),
    .pal_o (pal_d)
  );

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) pal_q <= pal_d;
  end

  // row emitter
  logic [3:0][31:0] row_d, out_texels_q;
  logic [7:0]       idx_row;
  logic [3:0][15:0] a2_rows;
  logic [3:0][11:0] a3_rows;
  logic [15:0]      a2_row;
  logic [11:0]      a3_row;

  assign idx_row = pal_q.col_rows[row_q];
  assign a2_rows = pal_q.alpha_raw;
  assign a3_rows = pal_q.alpha_raw[63:16];
  assign a2_row  = a2_rows[row_q];
  assign a3_row  = a3_rows[row_q];

  always_comb begin
    logic [1:0] idx;
    logic [3:0] nib;
    logic [7:0] alpha;
    for (int c = 0; c < 4; c++) begin
      idx = idx_row[2*c +: 2];
      nib = a2_row[4*c +: 4];
      unique case (pal_q.asrc)
        ASRC_COLOR:    alpha = (pal_q.transp3 && idx == 2'd3) ? 8'h00 : 8'hFF;
        ASRC_EXPLICIT: alpha = {nib, nib};
        ASRC_INTERP:   alpha = pal_q.apal[a3_row[3*c +: 3]];
        default:       alpha = 8'hFF;
      endcase
      if (pal_q.transp3 && idx == 2'd3) begin
        row_d[c] = {alpha, 24'h000000};
      end else begin
        row_d[c] = {alpha, pal_q.cpal[idx]};
      end
    end
  end

  // output register
  logic [1:0] out_row_q;

  always_ff @(posedge clk_i) begin
    if (s2_emit) begin
      out_texels_q <= row_d;
      out_row_q    <= row_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign texel_col0_o = out_texels_q[0];
  assign texel_col1_o = out_texels_q[1];
  assign texel_col2_o = out_texels_q[2];
  assign texel_col3_o = out_texels_q[3];
  assign row_index_o  = out_row_q;
  assign last_row_o   = (out_row_q == 2'd3);

`ifndef SYNTHESIS
  // rows of a block come out in order with no gap once one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=>
      out_valid_o && row_index_o == 2'($past(row_index_o) + 2'd1))
    else $error("row sequence broken");

  // row counter idles at zero between blocks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_valid_q |-> row_q == 2'd0)
    else $error("row counter not cleared");

  // finishing a block in the palette stage presents its last row next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_done |=> out_valid_o && last_row_o)
    else $error("last row not presented");
`endif

endmodule

FILE: rtl/core/bcdec_endpoints.sv
// Endpoint expansion and interpolation sums for one block.
module bcdec_endpoints (
  input  logic [63:0]          lo_i,
  input  logic [63:0]          hi_i,
  input  bcdec_pkg::asrc_e     asrc_i,
  output bcdec_pkg::ep_t       ep_o
);
  import bcdec_pkg::*;

  // v*255/31 truncated = 8v + floor(7v/31); the /31 by reciprocal 265/2^13
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0]  x;
    logic [15:0] p;
    begin
      x = 8'({v, 3'b000}) - 8'(v);
      p = 16'(x) * 16'd265;
      expand5 = 8'({v, 3'b000}) + 8'(p[15:13]);
    end
  endfunction

  // v*255/63 truncated = 4v + floor(v/21); the /21 by reciprocal 49/2^10
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [11:0] p;
    begin
      p = 12'(v) * 12'd49;
      expand6 = 8'({v, 2'b00}) + 8'(p[11:10]);
    end
  endfunction

  logic [63:0] blk;
  logic [15:0] c0, c1;
  logic [7:0]  a0, a1;
  logic        four_col, a_six;

  assign blk = (asrc_i == ASRC_COLOR) ? lo_i : hi_i;
  assign c0  = blk[15:0];
  assign c1  = blk[31:16];
  assign a0  = lo_i[7:0];
  assign a1  = lo_i[15:8];
  assign four_col = (asrc_i != ASRC_COLOR) || (c0 > c1);
  assign a_six = a0 > a1;

  always_comb begin
    ep_o = '0;
    ep_o.e0[0] = expand5(c0[15:11]);
    ep_o.e0[1] = expand6(c0[10:5]);
    ep_o.e0[2] = expand5(c0[4:0]);
    ep_o.e1[0] = expand5(c1[15:11]);
    ep_o.e1[1] = expand6(c1[10:5]);
    ep_o.e1[2] = expand5(c1[4:0]);
    for (int ch = 0; ch < 3; ch++) begin
      if (four_col) begin
        ep_o.sum_m[ch] = 10'({ep_o.e0[ch], 1'b0}) + 10'(ep_o.e1[ch]);
        ep_o.sum_n[ch] = 10'(ep_o.e0[ch]) + 10'({ep_o.e1[ch], 1'b0});
      end else begin
        ep_o.sum_m[ch] = 10'(ep_o.e0[ch]) + 10'(ep_o.e1[ch]);
        ep_o.sum_n[ch] = '0;
      end
    end
    // entry k+2: (6-k)*a0 + (k+1)*a1 in 8-step mode, (4-k)*a0 + (k+1)*a1 in 6-step
    for (int k = 0; k < 6; k++) begin
      if (a_six) begin
        ep_o.a_sum[k] = 11'(a0) * 11'(6 - k) + 11'(a1) * 11'(k + 1);
      end else if (k < 4) begin
        ep_o.a_sum[k] = 11'(a0) * 11'(4 - k) + 11'(a1) * 11'(k + 1);
      end else begin
        ep_o.a_sum[k] = '0;
      end
    end
    ep_o.four_col  = four_col;
    ep_o.a0        = a0;
    ep_o.a1        = a1;
    ep_o.a_six     = a_six;
    ep_o.col_rows  = blk[63:32];
    ep_o.alpha_raw = lo_i;
    ep_o.asrc      = asrc_i;
  end

endmodule

FILE: rtl/core/bcdec_palette.sv
// Colour and alpha palette construction from registered endpoint sums.
module bcdec_palette (
  input  bcdec_pkg::ep_t  ep_i,
  output bcdec_pkg::pal_t pal_o
);
  import bcdec_pkg::*;

  // x/3 for x <= 765
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [18:0] p;
    begin
      p = 19'(x) * 19'd683;
      div3 = p[18:11];
    end
  endfunction

  // x/5 for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    begin
      p = 22'(x) * 22'd3277;
      div5 = p[21:14];
    end
  endfunction

  // x/7 for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    begin
      p = 22'(x) * 22'd2341;
      div7 = p[21:14];
    end
  endfunction

  logic [2:0][7:0] m, n;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (ep_i.four_col) begin
        m[ch] = div3(ep_i.sum_m[ch]);
        n[ch] = div3(ep_i.sum_n[ch]);
      end else begin
        m[ch] = ep_i.sum_m[ch][8:1];
        n[ch] = '0;
      end
    end
  end

  always_comb begin
    pal_o = '0;
    pal_o.cpal[0] = {ep_i.e0[2], ep_i.e0[1], ep_i.e0[0]};
    pal_o.cpal[1] = {ep_i.e1[2], ep_i.e1[1], ep_i.e1[0]};
    pal_o.cpal[2] = {m[2], m[1], m[0]};
    pal_o.cpal[3] = {n[2], n[1], n[0]};
    pal_o.transp3 = !ep_i.four_col;
    pal_o.apal[0] = ep_i.a0;
    pal_o.apal[1] = ep_i.a1;
    for (int k = 0; k < 6; k++) begin
      if (ep_i.a_six) begin
        pal_o.apal[k+2] = div7(ep_i.a_sum[k]);
      end else if (k < 4) begin
        pal_o.apal[k+2] = div5(ep_i.a_sum[k]);
      end else if (k == 4) begin
        pal_o.apal[k+2] = 8'h00;
      end else begin
        pal_o.apal[k+2] = 8'hFF;
      end
    end
    pal_o.col_rows  = ep_i.col_rows;
    pal_o.alpha_raw = ep_i.alpha_raw;
    pal_o.asrc      = ep_i.asrc;
  end

endmodule
